>>> hw/rtl/dvrt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the route table.
package dvrt_pkg;

    localparam int MAX_NODES     = 16;
    localparam int MAX_NEIGHBORS = 10;
    localparam int RESULT_LIMIT  = 16;

    localparam int NODE_W = 5;
    localparam int W_W    = 16;
    localparam int COST_W = 24;
    localparam int DEG_W  = 4;
    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int LINKS  = MAX_NODES * MAX_NODES;
    localparam int RT_W   = COST_W + NODE_W;
    localparam int PASS_W = $clog2(MAX_NODES + 3);
    localparam int CNT_W  = $clog2(RESULT_LIMIT);

    localparam logic [COST_W-1:0] NO_ROUTE = COST_W'(999999);

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_DEL = 2'd1,
        OP_QRY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_REJ = 2'd1,
        ST_HOP = 2'd2,
        ST_UNR = 2'd3
    } status_t;

    typedef struct packed {
        logic              load_item;
        logic              w_wr;
        logic              w_swap;
        logic              link_add;
        logic              link_del;
        logic              init_wr;
        logic              relax_wr;
        logic              cap_w;
        logic              clr_changed;
        logic              cap_total;
        logic              out_load;
        logic [1:0]        out_status;
        logic [NODE_W-1:0] out_hop;
        logic              out_cost;
        logic              out_last;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  aux;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        op;
        logic              a_ok;
        logic              b_ok;
        logic              a_eq_b;
        logic              exists;
        logic              full;
        logic              pair_valid;
        logic              changed;
        logic              out_free;
        logic [NODE_W-1:0] n_act;
        logic [NODE_W-1:0] a_node;
        logic [NODE_W-1:0] b_node;
        logic [IDX_W-1:0]  a_idx;
        logic [IDX_W-1:0]  b_idx;
        logic [NODE_W-1:0] nh;
    } sts_t;

endpackage

>>> hw/rtl/dvrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/dvrt_datapath.sv
// Datapath: link table, route memories, relaxation arithmetic and output register.
module dvrt_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [4:0]       cfg_wdata,
    input  logic [31:0]      s_tdata,
    input  dvrt_pkg::cmd_t   cmd,
    output dvrt_pkg::sts_t   sts,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);

    logic [4:0]                  nc_reg;
    logic [1:0]                  op_reg;
    logic [dvrt_pkg::NODE_W-1:0] a_reg;
    logic [dvrt_pkg::NODE_W-1:0] b_reg;
    logic [dvrt_pkg::W_W-1:0]    cost_reg;
    logic [dvrt_pkg::LINKS-1:0]  valid_reg;
    logic [dvrt_pkg::DEG_W-1:0]  deg_reg [dvrt_pkg::MAX_NODES];
    logic [dvrt_pkg::W_W-1:0]    w_hold_reg;
    logic [dvrt_pkg::COST_W-1:0] total_reg;
    logic                        changed_reg;
    logic                        mv_reg;
    logic [1:0]                  ms_reg;
    logic [dvrt_pkg::NODE_W-1:0] mh_reg;
    logic [dvrt_pkg::COST_W-1:0] mc_reg;
    logic                        ml_reg;

    logic [dvrt_pkg::NODE_W-1:0] n_act;
    logic [dvrt_pkg::NODE_W-1:0] am1;
    logic [dvrt_pkg::NODE_W-1:0] bm1;
    logic [dvrt_pkg::IDX_W-1:0]  a_idx;
    logic [dvrt_pkg::IDX_W-1:0]  b_idx;
    logic [dvrt_pkg::ADDR_W-1:0] ab_addr;
    logic [dvrt_pkg::ADDR_W-1:0] ba_addr;
    logic [dvrt_pkg::ADDR_W-1:0] rc_addr;
    logic [dvrt_pkg::ADDR_W-1:0] ac_addr;
    logic [dvrt_pkg::W_W-1:0]    w_rdata;
    logic [dvrt_pkg::RT_W-1:0]   rt_a;
    logic [dvrt_pkg::RT_W-1:0]   rt_b;
    logic [dvrt_pkg::COST_W-1:0] cost_a;
    logic [dvrt_pkg::COST_W-1:0] cost_b;
    logic [dvrt_pkg::NODE_W-1:0] nh_b;
    logic [dvrt_pkg::COST_W-1:0] cand;
    logic [dvrt_pkg::NODE_W-1:0] aux_node;
    logic                        better;
    logic                        upd;
    logic [dvrt_pkg::RT_W-1:0]   init_ent;
    logic [dvrt_pkg::RT_W-1:0]   relax_ent;
    logic                        rt_we;
    logic [dvrt_pkg::RT_W-1:0]   rt_wdata;

    always_comb begin
        if (nc_reg == '0) begin
            n_act = dvrt_pkg::NODE_W'(1);
        end else if (nc_reg > dvrt_pkg::NODE_W'(dvrt_pkg::MAX_NODES)) begin
            n_act = dvrt_pkg::NODE_W'(dvrt_pkg::MAX_NODES);
        end else begin
            n_act = nc_reg;
        end
    end

    assign am1     = a_reg - dvrt_pkg::NODE_W'(1);
    assign bm1     = b_reg - dvrt_pkg::NODE_W'(1);
    assign a_idx   = am1[dvrt_pkg::IDX_W-1:0];
    assign b_idx   = bm1[dvrt_pkg::IDX_W-1:0];
    assign ab_addr = {a_idx, b_idx};
    assign ba_addr = {b_idx, a_idx};
    assign rc_addr = {cmd.row, cmd.col};
    assign ac_addr = {cmd.aux, cmd.col};

    assign sts.op         = op_reg;
    assign sts.a_ok       = (a_reg != '0) && (a_reg <= n_act);
    assign sts.b_ok       = (b_reg != '0) && (b_reg <= n_act);
    assign sts.a_eq_b     = (a_reg == b_reg);
    assign sts.exists     = valid_reg[ab_addr];
    assign sts.full       = (deg_reg[a_idx] >= dvrt_pkg::DEG_W'(dvrt_pkg::MAX_NEIGHBORS))
                         || (deg_reg[b_idx] >= dvrt_pkg::DEG_W'(dvrt_pkg::MAX_NEIGHBORS));
    assign sts.pair_valid = valid_reg[{cmd.row, cmd.aux}];
    assign sts.changed    = changed_reg;
    assign sts.out_free   = !mv_reg || m_tready;
    assign sts.n_act      = n_act;
    assign sts.a_node     = a_reg;
    assign sts.b_node     = b_reg;
    assign sts.a_idx      = a_idx;
    assign sts.b_idx      = b_idx;
    assign sts.nh         = nh_b;

    assign cost_a   = rt_a[dvrt_pkg::RT_W-1:dvrt_pkg::NODE_W];
    assign cost_b   = rt_b[dvrt_pkg::RT_W-1:dvrt_pkg::NODE_W];
    assign nh_b     = rt_b[dvrt_pkg::NODE_W-1:0];
    assign cand     = cost_a + dvrt_pkg::COST_W'(w_hold_reg);
    assign aux_node = dvrt_pkg::NODE_W'(cmd.aux) + dvrt_pkg::NODE_W'(1);
    assign better   = cand < cost_b;
    assign upd      = better || ((cand == cost_b) && (nh_b != '0) && (aux_node < nh_b));
    assign relax_ent = {(better ? cand : cost_b), aux_node};

    always_comb begin
        if (cmd.row == cmd.col) begin
            init_ent = {dvrt_pkg::COST_W'(0),
                        dvrt_pkg::NODE_W'(cmd.row) + dvrt_pkg::NODE_W'(1)};
        end else if ((dvrt_pkg::NODE_W'(cmd.row) < n_act)
                  && (dvrt_pkg::NODE_W'(cmd.col) < n_act) && valid_reg[rc_addr]) begin
            init_ent = {dvrt_pkg::COST_W'(w_rdata),
                        dvrt_pkg::NODE_W'(cmd.col) + dvrt_pkg::NODE_W'(1)};
        end else begin
            init_ent = {dvrt_pkg::NO_ROUTE, dvrt_pkg::NODE_W'(0)};
        end
    end

    assign rt_we    = cmd.init_wr || (cmd.relax_wr && upd);
    assign rt_wdata = cmd.init_wr ? init_ent : relax_ent;

    dvrt_ram #(.WIDTH(dvrt_pkg::W_W), .DEPTH(dvrt_pkg::LINKS)) u_weight (
        .aclk  (aclk),
        .we    (cmd.w_wr),
        .waddr (cmd.w_swap ? ba_addr : ab_addr),
        .wdata (cost_reg),
        .raddr (rc_addr),
        .rdata (w_rdata)
    );

    // Two copies of the route table give the neighbour row and own row in the same cycle
    dvrt_ram #(.WIDTH(dvrt_pkg::RT_W), .DEPTH(dvrt_pkg::LINKS)) u_route_a (
        .aclk  (aclk),
        .we    (rt_we),
        .waddr (rc_addr),
        .wdata (rt_wdata),
        .raddr (ac_addr),
        .rdata (rt_a)
    );

    dvrt_ram #(.WIDTH(dvrt_pkg::RT_W), .DEPTH(dvrt_pkg::LINKS)) u_route_b (
        .aclk  (aclk),
        .we    (rt_we),
        .waddr (rc_addr),
        .wdata (rt_wdata),
        .raddr (rc_addr),
        .rdata (rt_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg      <= 5'd16;
            valid_reg   <= '0;
            changed_reg <= 1'b0;
            mv_reg      <= 1'b0;
            for (int k = 0; k < dvrt_pkg::MAX_NODES; k++) begin
                deg_reg[k] <= '0;
            end
        end else begin
            if (cfg_we) begin
                nc_reg <= cfg_wdata;
            end
            if (cmd.link_add) begin
                valid_reg[ab_addr] <= 1'b1;
                valid_reg[ba_addr] <= 1'b1;
                deg_reg[a_idx]     <= deg_reg[a_idx] + dvrt_pkg::DEG_W'(1);
                deg_reg[b_idx]     <= deg_reg[b_idx] + dvrt_pkg::DEG_W'(1);
            end else if (cmd.link_del) begin
                valid_reg[ab_addr] <= 1'b0;
                valid_reg[ba_addr] <= 1'b0;
                deg_reg[a_idx]     <= deg_reg[a_idx] - dvrt_pkg::DEG_W'(1);
                deg_reg[b_idx]     <= deg_reg[b_idx] - dvrt_pkg::DEG_W'(1);
            end
            if (cmd.clr_changed) begin
                changed_reg <= 1'b0;
            end else if (cmd.relax_wr && upd) begin
                changed_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg   <= s_tdata[1:0];
            a_reg    <= s_tdata[6:2];
            b_reg    <= s_tdata[11:7];
            cost_reg <= s_tdata[27:12];
        end
        if (cmd.cap_w) begin
            w_hold_reg <= w_rdata;
        end
        if (cmd.cap_total) begin
            total_reg <= cost_b;
        end
        if (cmd.out_load) begin
            ms_reg <= cmd.out_status;
            mh_reg <= cmd.out_hop;
            mc_reg <= cmd.out_cost ? total_reg : '0;
            ml_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {1'b0, mc_reg, mh_reg, ms_reg};
    assign m_tlast  = ml_reg;

endmodule

>>> hw/rtl/dvrt_ctrl.sv
// Controller: sequences link changes, the relaxation sweeps and route walks.
module dvrt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  dvrt_pkg::sts_t sts,
    output dvrt_pkg::cmd_t cmd
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_DECODE   = 17'h00002,
        S_WR_AB    = 17'h00004,
        S_WR_BA    = 17'h00008,
        S_INIT_RD  = 17'h00010,
        S_INIT_WR  = 17'h00020,
        S_PAIR     = 17'h00040,
        S_W_CAP    = 17'h00080,
        S_D_RD     = 17'h00100,
        S_D_WR     = 17'h00200,
        S_PASS_END = 17'h00400,
        S_EMIT     = 17'h00800,
        S_Q_RD0    = 17'h01000,
        S_Q_CHK0   = 17'h02000,
        S_Q_RD     = 17'h04000,
        S_Q_CHK    = 17'h08000,
        S_RSVD     = 17'h10000
    } state_t;

    state_t                      state_reg, state_next;
    logic                        pend_reg, pend_next;
    logic                        emit_reg, emit_next;
    logic [1:0]                  res_reg, res_next;
    logic [dvrt_pkg::IDX_W-1:0]  i_reg, i_next;
    logic [dvrt_pkg::IDX_W-1:0]  j_reg, j_next;
    logic [dvrt_pkg::IDX_W-1:0]  d_reg, d_next;
    logic [dvrt_pkg::PASS_W-1:0] pass_reg, pass_next;
    logic [dvrt_pkg::NODE_W-1:0] cur_reg, cur_next;
    logic [dvrt_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic [dvrt_pkg::NODE_W-1:0] n_m1;
    logic [dvrt_pkg::IDX_W-1:0]  last_idx;
    logic [dvrt_pkg::NODE_W-1:0] cur_m1;
    logic [dvrt_pkg::PASS_W-1:0] pass_inc;
    logic                        bad_ends;
    logic                        hop_last;
    logic                        adv_d;
    logic                        adv_p;

    localparam logic [dvrt_pkg::IDX_W-1:0] MAX_IDX = dvrt_pkg::IDX_W'(dvrt_pkg::MAX_NODES - 1);
    localparam logic [dvrt_pkg::CNT_W-1:0] CNT_MAX = dvrt_pkg::CNT_W'(dvrt_pkg::RESULT_LIMIT - 1);

    assign n_m1     = sts.n_act - dvrt_pkg::NODE_W'(1);
    assign last_idx = n_m1[dvrt_pkg::IDX_W-1:0];
    assign cur_m1   = cur_reg - dvrt_pkg::NODE_W'(1);
    assign pass_inc = pass_reg + dvrt_pkg::PASS_W'(1);
    assign bad_ends = !sts.a_ok || !sts.b_ok || sts.a_eq_b;
    assign hop_last = (cur_reg == sts.b_node) || (cnt_reg == CNT_MAX)
                   || (sts.nh == '0) || (sts.nh > sts.n_act);
    assign s_tready = (state_reg == S_IDLE) && !pend_reg;

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        emit_next  = emit_reg;
        res_next   = res_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        d_next     = d_reg;
        pass_next  = pass_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        adv_d      = 1'b0;
        adv_p      = 1'b0;
        cmd        = '0;
        cmd.row    = i_reg;
        cmd.col    = d_reg;
        cmd.aux    = j_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (pend_reg) begin
                    pend_next  = 1'b0;
                    emit_next  = 1'b0;
                    i_next     = '0;
                    d_next     = '0;
                    state_next = S_INIT_RD;
                end else if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.op)
                    dvrt_pkg::OP_SET: begin
                        if (bad_ends || (!sts.exists && sts.full)) begin
                            res_next   = dvrt_pkg::ST_REJ;
                            state_next = S_EMIT;
                        end else begin
                            cmd.link_add = !sts.exists;
                            state_next   = S_WR_AB;
                        end
                    end
                    dvrt_pkg::OP_DEL: begin
                        if (bad_ends) begin
                            res_next   = dvrt_pkg::ST_REJ;
                            state_next = S_EMIT;
                        end else if (sts.exists) begin
                            cmd.link_del = 1'b1;
                            res_next     = dvrt_pkg::ST_OK;
                            emit_next    = 1'b1;
                            i_next       = '0;
                            d_next       = '0;
                            state_next   = S_INIT_RD;
                        end else begin
                            res_next   = dvrt_pkg::ST_OK;
                            state_next = S_EMIT;
                        end
                    end
                    dvrt_pkg::OP_QRY: begin
                        if (!sts.a_ok || !sts.b_ok) begin
                            res_next   = dvrt_pkg::ST_UNR;
                            state_next = S_EMIT;
                        end else begin
                            state_next = S_Q_RD0;
                        end
                    end
                    default: begin
                        res_next   = dvrt_pkg::ST_REJ;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_WR_AB: begin
                cmd.w_wr   = 1'b1;
                state_next = S_WR_BA;
            end
            S_WR_BA: begin
                cmd.w_wr   = 1'b1;
                cmd.w_swap = 1'b1;
                res_next   = dvrt_pkg::ST_OK;
                emit_next  = 1'b1;
                i_next     = '0;
                d_next     = '0;
                state_next = S_INIT_RD;
            end
            S_INIT_RD: begin
                state_next = S_INIT_WR;
            end
            S_INIT_WR: begin
                cmd.init_wr = 1'b1;
                state_next  = S_INIT_RD;
                if (d_reg == MAX_IDX) begin
                    d_next = '0;
                    if (i_reg == MAX_IDX) begin
                        i_next          = '0;
                        j_next          = '0;
                        pass_next       = '0;
                        cmd.clr_changed = 1'b1;
                        state_next      = S_PAIR;
                    end else begin
                        i_next = i_reg + dvrt_pkg::IDX_W'(1);
                    end
                end else begin
                    d_next = d_reg + dvrt_pkg::IDX_W'(1);
                end
            end
            S_PAIR: begin
                cmd.col = j_reg;
                if (sts.pair_valid && (i_reg != j_reg)) begin
                    state_next = S_W_CAP;
                end else begin
                    adv_p = 1'b1;
                end
            end
            S_W_CAP: begin
                cmd.col    = j_reg;
                cmd.cap_w  = 1'b1;
                d_next     = '0;
                state_next = S_D_RD;
            end
            S_D_RD: begin
                if (d_reg == i_reg) begin
                    adv_d = 1'b1;
                end else begin
                    state_next = S_D_WR;
                end
            end
            S_D_WR: begin
                cmd.relax_wr = 1'b1;
                adv_d        = 1'b1;
            end
            S_PASS_END: begin
                if (sts.changed
                    && (pass_inc < dvrt_pkg::PASS_W'(sts.n_act) + dvrt_pkg::PASS_W'(2))) begin
                    pass_next       = pass_inc;
                    cmd.clr_changed = 1'b1;
                    i_next          = '0;
                    j_next          = '0;
                    state_next      = S_PAIR;
                end else begin
                    state_next = emit_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = res_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_Q_RD0: begin
                cmd.row    = sts.a_idx;
                cmd.col    = sts.b_idx;
                state_next = S_Q_CHK0;
            end
            S_Q_CHK0: begin
                cmd.row = sts.a_idx;
                cmd.col = sts.b_idx;
                if (sts.nh == '0) begin
                    res_next   = dvrt_pkg::ST_UNR;
                    state_next = S_EMIT;
                end else begin
                    cmd.cap_total = 1'b1;
                    cur_next      = sts.a_node;
                    cnt_next      = '0;
                    state_next    = S_Q_RD;
                end
            end
            S_Q_RD: begin
                cmd.row    = cur_m1[dvrt_pkg::IDX_W-1:0];
                cmd.col    = sts.b_idx;
                state_next = S_Q_CHK;
            end
            S_Q_CHK: begin
                cmd.row = cur_m1[dvrt_pkg::IDX_W-1:0];
                cmd.col = sts.b_idx;
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = dvrt_pkg::ST_HOP;
                    cmd.out_hop    = cur_reg;
                    cmd.out_cost   = 1'b1;
                    cmd.out_last   = hop_last;
                    if (hop_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cur_next   = sts.nh;
                        cnt_next   = cnt_reg + dvrt_pkg::CNT_W'(1);
                        state_next = S_Q_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Step the destination, then the neighbour pair, of the relaxation sweep
        if (adv_d) begin
            if (d_reg == last_idx) begin
                adv_p = 1'b1;
            end else begin
                d_next     = d_reg + dvrt_pkg::IDX_W'(1);
                state_next = S_D_RD;
            end
        end
        if (adv_p) begin
            if (j_reg == last_idx) begin
                j_next = '0;
                if (i_reg == last_idx) begin
                    state_next = S_PASS_END;
                end else begin
                    i_next     = i_reg + dvrt_pkg::IDX_W'(1);
                    state_next = S_PAIR;
                end
            end else begin
                j_next     = j_reg + dvrt_pkg::IDX_W'(1);
                state_next = S_PAIR;
            end
        end

        if (cfg_we) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b1;
            emit_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        d_reg    <= d_next;
        pass_reg <= pass_next;
        cur_reg  <= cur_next;
        cnt_reg  <= cnt_next;
    end

endmodule

>>> hw/rtl/distance_vector_route_table.sv
// Top level of the distance-vector route table: controller, datapath and checks.
//
//  channel | direction | payload
//  s_      | in        | tdata: op, node_a, node_b, link_cost
//  m_      | out       | tdata: status, hop_node, path_cost; tlast: last
//  cfg_    | in        | node_count
//
// A link change that alters the table runs a table rebuild plus up to n+2 relaxation
// passes (n = nodes in use). A query returns one result per path node, other items one.
// After reset and after each node_count write the same rebuild runs before input is taken.
// The output register holds one result; a stalled m_ side holds the controller at its
// next result, and no new input is taken until that result is loaded.
module distance_vector_route_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // op[1:0], node_a[6:2], node_b[11:7], link_cost[27:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[1:0], hop_node[6:2], path_cost[30:7]
    output logic        m_tlast
);

    dvrt_pkg::cmd_t cmd;
    dvrt_pkg::sts_t sts;

    dvrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dvrt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice without processing");

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input taken before route rebuild after node count write");

endmodule

>>> verif/tb_distance_vector_route_table.sv
// Self-checking testbench for the distance-vector route table: directed and random phases.
module tb_distance_vector_route_table;

    typedef struct {
        logic [1:0]  status;
        logic [4:0]  hop;
        logic [23:0] cost;
        logic        last;
    } route_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // op[1:0], node_a[6:2], node_b[11:7], link_cost[27:12]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // status[1:0], hop_node[6:2], path_cost[30:7]
    logic        m_tlast;

    distance_vector_route_table dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // mirror of the table
    bit          lk_valid [dvrt_pkg::MAX_NODES][dvrt_pkg::MAX_NODES];
    int          lk_weight[dvrt_pkg::MAX_NODES][dvrt_pkg::MAX_NODES];
    int          degree   [dvrt_pkg::MAX_NODES];
    int          rt_cost  [dvrt_pkg::MAX_NODES][dvrt_pkg::MAX_NODES];
    int          rt_next  [dvrt_pkg::MAX_NODES][dvrt_pkg::MAX_NODES];
    int          nodes_cfg;
    route_result_t expected_routes[$];

    int errors;
    int src_idle_pct;
    int snk_idle_pct;
    int hold_left;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 40_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int active_nodes();
        if (nodes_cfg < 1) return 1;
        if (nodes_cfg > dvrt_pkg::MAX_NODES) return dvrt_pkg::MAX_NODES;
        return nodes_cfg;
    endfunction

    function automatic void relax_routes();
        int n;
        bit changed;
        int cand;
        n = active_nodes();
        changed = 1;
        for (int i = 0; i < dvrt_pkg::MAX_NODES; i++) begin
            for (int d = 0; d < dvrt_pkg::MAX_NODES; d++) begin
                rt_cost[i][d] = int'(dvrt_pkg::NO_ROUTE);
                rt_next[i][d] = 0;
            end
            rt_cost[i][i] = 0;
            rt_next[i][i] = i + 1;
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (lk_valid[i][j] && i != j) begin
                    rt_cost[i][j] = lk_weight[i][j];
                    rt_next[i][j] = j + 1;
                end
        for (int p = 0; changed && p < n + 2; p++) begin
            changed = 0;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    if (!lk_valid[i][j] || i == j) continue;
                    for (int d = 0; d < n; d++) begin
                        if (d == i) continue;
                        cand = rt_cost[j][d] + lk_weight[i][j];
                        if (cand < rt_cost[i][d]) begin
                            rt_cost[i][d] = cand;
                            rt_next[i][d] = j + 1;
                            changed = 1;
                        end else if (cand == rt_cost[i][d] && rt_next[i][d] != 0 &&
                                     j + 1 < rt_next[i][d]) begin
                            rt_next[i][d] = j + 1;
                            changed = 1;
                        end
                    end
                end
        end
    endfunction

    function automatic void push_route(logic [1:0] st, int hop, int cost, bit last);
        route_result_t r;
        r.status = st;
        r.hop    = hop[4:0];
        r.cost   = cost[23:0];
        r.last   = last;
        expected_routes.push_back(r);
    endfunction

    function automatic void predict_routes(logic [31:0] data);
        logic [1:0] op;
        int a, b, w, n, cur, cnt, total;
        bit a_ok, b_ok;
        op = data[1:0];
        a  = data[6:2];
        b  = data[11:7];
        w  = data[27:12];
        n  = active_nodes();
        a_ok = a >= 1 && a <= n;
        b_ok = b >= 1 && b <= n;
        if (op == dvrt_pkg::OP_SET || op == dvrt_pkg::OP_DEL) begin
            if (!a_ok || !b_ok || a == b) begin
                push_route(dvrt_pkg::ST_REJ, 0, 0, 1);
                return;
            end
            if (op == dvrt_pkg::OP_SET) begin
                if (!lk_valid[a-1][b-1]) begin
                    if (degree[a-1] >= dvrt_pkg::MAX_NEIGHBORS ||
                        degree[b-1] >= dvrt_pkg::MAX_NEIGHBORS) begin
                        push_route(dvrt_pkg::ST_REJ, 0, 0, 1);
                        return;
                    end
                    lk_valid[a-1][b-1] = 1;
                    lk_valid[b-1][a-1] = 1;
                    degree[a-1]++;
                    degree[b-1]++;
                end
                lk_weight[a-1][b-1] = w;
                lk_weight[b-1][a-1] = w;
                relax_routes();
            end else if (lk_valid[a-1][b-1]) begin
                lk_valid[a-1][b-1] = 0;
                lk_valid[b-1][a-1] = 0;
                degree[a-1]--;
                degree[b-1]--;
                relax_routes();
            end
            push_route(dvrt_pkg::ST_OK, 0, 0, 1);
        end else if (op == dvrt_pkg::OP_QRY) begin
            if (!a_ok || !b_ok || rt_next[a-1][b-1] == 0) begin
                push_route(dvrt_pkg::ST_UNR, 0, 0, 1);
                return;
            end
            total = rt_cost[a-1][b-1];
            cur = a;
            cnt = 0;
            forever begin
                push_route(dvrt_pkg::ST_HOP, cur, total, 0);
                cnt++;
                if (cur == b || cnt >= dvrt_pkg::RESULT_LIMIT) break;
                if (rt_next[cur-1][b-1] < 1 || rt_next[cur-1][b-1] > n) break;
                cur = rt_next[cur-1][b-1];
            end
            expected_routes[$].last = 1;
        end else begin
            push_route(dvrt_pkg::ST_REJ, 0, 0, 1);
        end
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 0;
                hold_left--;
            end else
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // compare every result transaction with the oldest expectation
    initial begin
        route_result_t e;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_routes.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else begin
                    e = expected_routes.pop_front();
                    if (m_tdata[1:0] !== e.status)
                        report_mismatch($sformatf("status %0d, want %0d", m_tdata[1:0], e.status));
                    if (m_tdata[6:2] !== e.hop)
                        report_mismatch($sformatf("hop %0d, want %0d", m_tdata[6:2], e.hop));
                    if (m_tdata[30:7] !== e.cost)
                        report_mismatch($sformatf("cost %0d, want %0d", m_tdata[30:7], e.cost));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("last %0b, want %0b", m_tlast, e.last));
                end
            end
        end
    end

    task automatic send_item(logic [1:0] op, int a, int b, int w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 0;
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata  <= {4'd0, w[15:0], b[4:0], a[4:0], op};
        do @(posedge aclk); while (!s_tready);
        predict_routes({4'd0, w[15:0], b[4:0], a[4:0], op});
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 0;
        while (expected_routes.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_node_count(int value);
        wait_drained();
        @(negedge aclk);
        cfg_we    <= 1;
        cfg_wdata <= value[4:0];
        @(negedge aclk);
        cfg_we    <= 0;
        nodes_cfg = value;
        relax_routes();
    endtask

    task automatic test_directed();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_item(dvrt_pkg::OP_QRY, 1, 1, 0);
        send_item(dvrt_pkg::OP_QRY, 1, 2, 0);
        send_item(dvrt_pkg::OP_QRY, 0, 5, 0);
        send_item(dvrt_pkg::OP_QRY, 3, 31, 0);
        send_item(dvrt_pkg::OP_SET, 3, 3, 7);
        send_item(dvrt_pkg::OP_SET, 0, 2, 7);
        send_item(dvrt_pkg::OP_SET, 17, 2, 7);
        send_item(2'd3, 1, 2, 9);
        send_item(dvrt_pkg::OP_DEL, 1, 2, 0);
        for (int k = 2; k <= 11; k++) send_item(dvrt_pkg::OP_SET, 1, k, k == 3 ? 0 : k);
        send_item(dvrt_pkg::OP_SET, 1, 12, 1);
        send_item(dvrt_pkg::OP_SET, 1, 2, 65535);
        send_item(dvrt_pkg::OP_QRY, 2, 11, 0);
        send_item(dvrt_pkg::OP_DEL, 1, 5, 0);
        send_item(dvrt_pkg::OP_QRY, 5, 1, 0);
    endtask

    // chain across every node, walk the longest path
    task automatic test_long_path();
        for (int k = 2; k <= 11; k++) send_item(dvrt_pkg::OP_DEL, 1, k, 0);
        for (int k = 1; k < dvrt_pkg::MAX_NODES; k++)
            send_item(dvrt_pkg::OP_SET, k, k + 1, 65535);
        send_item(dvrt_pkg::OP_QRY, 1, 16, 0);
        send_item(dvrt_pkg::OP_QRY, 16, 2, 0);
    endtask

    task automatic test_random(int n_items);
        int n, op, a, b, w, pick;
        n = active_nodes();
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                op = $urandom_range(0, 3);
                a  = $urandom_range(0, 31);
                b  = $urandom_range(0, 31);
            end else begin
                op = pick < 45 ? dvrt_pkg::OP_SET
                   : (pick < 60 ? dvrt_pkg::OP_DEL : dvrt_pkg::OP_QRY);
                a  = $urandom_range(1, n);
                b  = $urandom_range(1, n);
            end
            case ($urandom_range(0, 3))
                0: w = $urandom_range(0, 3);
                1: w = 65535;
                default: w = $urandom_range(0, 65535);
            endcase
            send_item(op[1:0], a, b, w);
        end
    endtask

    // hold the result side while queries keep arriving
    task automatic test_backpressure();
        @(negedge aclk);
        hold_left = 3000;
        for (int i = 0; i < 8; i++)
            send_item(dvrt_pkg::OP_QRY, $urandom_range(1, 5), $urandom_range(1, 5), 0);
        wait_drained();
    endtask

    initial begin
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        errors = 0;
        hold_left = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        nodes_cfg = dvrt_pkg::MAX_NODES;
        relax_routes();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        test_directed();
        test_long_path();
        write_node_count(1);
        test_random(4);
        write_node_count(5);
        src_idle_pct = 50;
        test_random(15);
        test_backpressure();
        write_node_count(6);
        src_idle_pct = 0;
        snk_idle_pct = 50;
        test_random(15);
        write_node_count(4);
        src_idle_pct = 26;
        snk_idle_pct = 26;
        test_random(15);
        write_node_count(15);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(12);
        write_node_count(16);
        snk_idle_pct = 50;
        test_random(8);
        write_node_count(7);
        src_idle_pct = 26;
        snk_idle_pct = 26;
        test_random(12);
        wait_drained();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/dvrt_pkg.sv
hw/rtl/dvrt_ram.sv
hw/rtl/dvrt_datapath.sv
hw/rtl/dvrt_ctrl.sv
hw/rtl/distance_vector_route_table.sv
verif/tb_distance_vector_route_table.sv
